FILE: hw/rtl/lr_table_parse_engine_assert.svh
// assertion macros shared by the checker
`ifndef LR_TABLE_PARSE_ENGINE_ASSERT_SVH
`define LR_TABLE_PARSE_ENGINE_ASSERT_SVH

// property checked on every clock edge outside reset
`define LRPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property that must hold during reset as well
`define LRPE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/lrpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpe_pkg
// shared constants, payload types and controller/datapath interface types
// ----------------------------------------------------------------------------
package lrpe_pkg;

  localparam int STACK_DEPTH    = 512;
  localparam int SP_W           = $clog2(STACK_DEPTH);
  localparam int LC_W           = SP_W + 1;
  localparam int TABLE_AW       = 12;
  localparam int TABLE_DEPTH    = 1 << TABLE_AW;
  localparam int NUM_TABLES     = 14;
  localparam int TBL_ID_W       = 4;
  localparam int TBL_ADDR_W     = TBL_ID_W + TABLE_AW;
  localparam int TBL_SIZE       = NUM_TABLES * TABLE_DEPTH;
  localparam int IDX_W          = 18;
  localparam int MAX_REDUCTIONS = 63;
  localparam int NRED_W         = $clog2(MAX_REDUCTIONS + 1);
  localparam int ST_W           = 12;
  localparam int TOK_W          = 10;
  localparam int WORD_W         = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 12;

  // opcodes
  localparam logic [1:0] OPC_START = 2'd0;
  localparam logic [1:0] OPC_TOKEN = 2'd1;
  localparam logic [1:0] OPC_WRITE = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_REDUCE    = 3'd0;
  localparam logic [2:0] KIND_SHIFTED   = 3'd1;
  localparam logic [2:0] KIND_ACCEPTED  = 3'd2;
  localparam logic [2:0] KIND_ERROR     = 3'd3;
  localparam logic [2:0] KIND_SUSPENDED = 3'd4;
  localparam logic [2:0] KIND_OVERFLOW  = 3'd5;
  localparam logic [2:0] KIND_DONE      = 3'd6;

  // table ids
  localparam logic [TBL_ID_W-1:0] TBL_BM = 4'd0;
  localparam logic [TBL_ID_W-1:0] TBL_BR = 4'd1;
  localparam logic [TBL_ID_W-1:0] TBL_BC = 4'd2;
  localparam logic [TBL_ID_W-1:0] TBL_BF = 4'd3;
  localparam logic [TBL_ID_W-1:0] TBL_TM = 4'd4;
  localparam logic [TBL_ID_W-1:0] TBL_TR = 4'd5;
  localparam logic [TBL_ID_W-1:0] TBL_TC = 4'd6;
  localparam logic [TBL_ID_W-1:0] TBL_NM = 4'd7;
  localparam logic [TBL_ID_W-1:0] TBL_NR = 4'd8;
  localparam logic [TBL_ID_W-1:0] TBL_NC = 4'd9;
  localparam logic [TBL_ID_W-1:0] TBL_RM = 4'd10;
  localparam logic [TBL_ID_W-1:0] TBL_RR = 4'd11;
  localparam logic [TBL_ID_W-1:0] TBL_RC = 4'd12;
  localparam logic [TBL_ID_W-1:0] TBL_PL = 4'd13;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_STATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EOF_TOKEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEX_MODE     = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [TOK_W-1:0]         token_code;
    logic [TBL_ID_W-1:0]      table_id;
    logic [11:0]              table_index;
    logic signed [WORD_W-1:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [ST_W-1:0] production;
    logic [ST_W-1:0] parser_state;
    logic [9:0]      stack_depth;
    logic            last;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_EMIT_DONE, OP_RD_BR, OP_RD_BC, OP_RD_BM, OP_RD_BF,
    OP_PUSH_X, OP_RD_TC, OP_RD_TM, OP_SET_P, OP_SHIFT_DONE, OP_RD_PL, OP_POP,
    OP_EMIT_RED, OP_RD_NC, OP_RD_NM, OP_SET_X, OP_RD_RR, OP_RD_RC, OP_RD_RM,
    OP_SET_PR, OP_NPUSH, OP_EMIT_NULL, OP_RD_PL0, OP_SET_FAIL, OP_SET_OVF,
    OP_ACCEPT, OP_RESTORE, OP_RD_LOG, OP_UNDO, OP_EMIT_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       tok_zero;
    logic       bits_nz;
    logic       tv_le0;
    logic       tv_gt0;
    logic       tv_lt0;
    logic       tv_m1;
    logic       push_ovf;
    logic       pop_ovf;
    logic       log_full;
    logic       log_empty;
    logic       nred_max;
    logic       x_is_acc;
    logic       out_free;
  } stat_t;

  typedef struct packed {
    logic [SP_W-1:0] sp;
    logic [ST_W-1:0] st;
  } log_t;

endpackage

FILE: hw/rtl/lrpe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpe_ctrl
// sequencer for table walks, reduction chains and stack restore
// ----------------------------------------------------------------------------
module lrpe_ctrl import lrpe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  in_stall_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DONE = 5'd1;
  localparam logic [4:0] S_L1   = 5'd2;
  localparam logic [4:0] S_L2   = 5'd3;
  localparam logic [4:0] S_L3   = 5'd4;
  localparam logic [4:0] S_L4   = 5'd5;
  localparam logic [4:0] S_L5   = 5'd6;
  localparam logic [4:0] S_S1   = 5'd7;
  localparam logic [4:0] S_S2   = 5'd8;
  localparam logic [4:0] S_S3   = 5'd9;
  localparam logic [4:0] S_S4   = 5'd10;
  localparam logic [4:0] S_C1   = 5'd11;
  localparam logic [4:0] S_C2   = 5'd12;
  localparam logic [4:0] S_C3   = 5'd13;
  localparam logic [4:0] S_C4   = 5'd14;
  localparam logic [4:0] S_C5   = 5'd15;
  localparam logic [4:0] S_C6   = 5'd16;
  localparam logic [4:0] S_R1   = 5'd17;
  localparam logic [4:0] S_R2   = 5'd18;
  localparam logic [4:0] S_R3   = 5'd19;
  localparam logic [4:0] S_R4   = 5'd20;
  localparam logic [4:0] S_R5   = 5'd21;
  localparam logic [4:0] S_R6   = 5'd22;
  localparam logic [4:0] S_R7   = 5'd23;
  localparam logic [4:0] S_A1   = 5'd24;
  localparam logic [4:0] S_A2   = 5'd25;
  localparam logic [4:0] S_X1   = 5'd26;
  localparam logic [4:0] S_X2   = 5'd27;
  localparam logic [4:0] S_FIN  = 5'd28;

  logic [4:0] state_d, state_q;
  logic       mode_d, mode_q;   // 1: chain after a shift, 0: lookahead reduce
  dp_op_e     op;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    op      = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op = OP_LOAD;
          unique case (stat_i.in_op)
            OPC_START, OPC_WRITE: state_d = S_DONE;
            OPC_TOKEN:            state_d = stat_i.tok_zero ? S_X1 : S_L1;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          op      = OP_EMIT_DONE;
          state_d = S_IDLE;
        end
      end
      S_L1: begin op = OP_RD_BR; state_d = S_L2; end
      S_L2: begin op = OP_RD_BC; state_d = S_L3; end
      S_L3: begin op = OP_RD_BM; state_d = S_L4; end
      S_L4: begin op = OP_RD_BF; state_d = S_L5; end
      S_L5: state_d = stat_i.bits_nz ? S_S1 : S_R1;
      S_S1: begin
        mode_d = 1'b1;
        if (stat_i.push_ovf) begin
          op      = OP_SET_OVF;
          state_d = S_X1;
        end else begin
          op      = OP_PUSH_X;
          state_d = S_S2;
        end
      end
      S_S2: begin op = OP_RD_TC; state_d = S_S3; end
      S_S3: begin op = OP_RD_TM; state_d = S_S4; end
      S_S4: begin
        if (stat_i.tv_le0) begin
          op      = OP_SET_P;
          state_d = S_C1;
        end else begin
          op      = OP_SHIFT_DONE;
          state_d = S_FIN;
        end
      end
      S_C1: begin op = OP_RD_PL; state_d = S_C2; end
      S_C2: begin
        if (stat_i.pop_ovf) begin
          op      = OP_SET_OVF;
          state_d = S_X1;
        end else begin
          op      = OP_POP;
          state_d = S_C3;
        end
      end
      S_C3: begin
        if (stat_i.nred_max) begin
          op      = OP_SET_OVF;
          state_d = S_X1;
        end else if (stat_i.out_free) begin
          op      = OP_EMIT_RED;
          state_d = S_C4;
        end
      end
      S_C4: begin op = OP_RD_NC; state_d = S_C5; end
      S_C5: begin op = OP_RD_NM; state_d = S_C6; end
      S_C6: begin
        if (mode_q) begin
          if (stat_i.tv_le0) begin
            op      = OP_SET_P;
            state_d = S_C1;
          end else begin
            op      = OP_SHIFT_DONE;
            state_d = S_FIN;
          end
        end else if (stat_i.tv_lt0) begin
          op      = OP_SET_P;
          state_d = S_C1;
        end else begin
          op      = OP_SET_X;
          state_d = S_L1;
        end
      end
      S_R1: begin op = OP_RD_RR; mode_d = 1'b0; state_d = S_R2; end
      S_R2: begin
        if (stat_i.tv_le0) begin
          op      = OP_RD_RC;
          state_d = S_R3;
        end else begin
          op      = OP_SET_PR;
          state_d = S_R5;
        end
      end
      S_R3: begin op = OP_RD_RM; state_d = S_R4; end
      S_R4: begin
        if (stat_i.tv_gt0) begin
          op      = OP_SET_PR;
          state_d = S_R5;
        end else begin
          state_d = S_A1;
        end
      end
      S_R5: begin op = OP_RD_PL; state_d = S_R6; end
      S_R6: begin
        if (!stat_i.tv_m1) begin
          state_d = S_C1;
        end else if (stat_i.push_ovf || stat_i.log_full) begin
          op      = OP_SET_OVF;
          state_d = S_X1;
        end else begin
          op      = OP_NPUSH;
          state_d = S_R7;
        end
      end
      S_R7: begin
        if (stat_i.nred_max) begin
          op      = OP_SET_OVF;
          state_d = S_X1;
        end else if (stat_i.out_free) begin
          op      = OP_EMIT_NULL;
          state_d = S_C4;
        end
      end
      S_A1: begin
        if (stat_i.x_is_acc) begin
          op      = OP_RD_PL0;
          state_d = S_A2;
        end else begin
          op      = OP_SET_FAIL;
          state_d = S_X1;
        end
      end
      S_A2: begin
        if (stat_i.pop_ovf) begin
          op      = OP_SET_OVF;
          state_d = S_X1;
        end else begin
          op      = OP_ACCEPT;
          state_d = S_FIN;
        end
      end
      S_X1: begin
        if (stat_i.log_empty) begin
          op      = OP_RESTORE;
          state_d = S_FIN;
        end else begin
          op      = OP_RD_LOG;
          state_d = S_X2;
        end
      end
      S_X2: begin op = OP_UNDO; state_d = S_X1; end
      S_FIN: begin
        if (stat_i.out_free) begin
          op      = OP_EMIT_FIN;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  assign cmd_o.op   = op;
  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: hw/rtl/lrpe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpe_dp
// parse tables, state stack, undo log, working registers and result register
// ----------------------------------------------------------------------------
module lrpe_dp import lrpe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  in_item_t              in_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  // config
  logic [ST_W-1:0]  accept_q;
  logic [TOK_W-1:0] eof_q;
  logic             lex_q;

  // architectural state
  logic [ST_W-1:0] cs_q, cs_d;
  logic [SP_W-1:0] st_q, st_d;
  logic [ST_W-1:0] sv_state_q, sv_state_d;
  logic [SP_W-1:0] sv_top_q, sv_top_d;
  logic [LC_W-1:0] log_cnt_q, log_cnt_d;

  // working registers
  logic [ST_W-1:0]          x_q, x_d;
  logic [TOK_W-1:0]         t_q, t_d;
  logic [SP_W-1:0]          wsp_q, wsp_d;
  logic signed [WORD_W-1:0] acc_q, acc_d;
  logic signed [WORD_W:0]   p_q, p_d;
  logic [NRED_W-1:0]        nred_q, nred_d;
  logic [2:0]               kind_q, kind_d;

  // memories
  logic [WORD_W-1:0] tbl_mem [TBL_SIZE];
  logic [ST_W-1:0]   stk_mem [STACK_DEPTH];
  log_t              log_mem [STACK_DEPTH];
  logic [WORD_W-1:0] tbl_q;
  logic              oob_q;
  logic [ST_W-1:0]   stk_q;
  log_t              log_q;

  logic                    tbl_we, tbl_re;
  logic [TBL_ADDR_W-1:0]   tbl_waddr, tbl_raddr;
  logic [TBL_ID_W-1:0]     rd_tab;
  logic signed [IDX_W-1:0] rd_idx;
  logic                    rd_inrange;

  logic            stk_we, stk_re;
  logic [SP_W-1:0] stk_waddr, stk_raddr;
  logic [ST_W-1:0] stk_wdata;
  logic            log_we, log_re;
  log_t            log_wdata;
  logic [LC_W-1:0] log_rd_cnt;

  logic signed [WORD_W-1:0] tv;
  logic signed [IDX_W-1:0]  sum_idx, diff_idx, pop_n;
  logic [SP_W-1:0]          pop_sat, wsp_inc;

  logic      out_valid_q, emit;
  out_item_t out_q, emit_item;

  assign tv       = oob_q ? '0 : $signed(tbl_q);
  assign sum_idx  = IDX_W'(acc_q) + IDX_W'(tv);
  assign diff_idx = IDX_W'(tv) - IDX_W'(acc_q);
  assign pop_n    = $signed(IDX_W'(wsp_q)) - IDX_W'(tv);
  assign pop_sat  = pop_n[IDX_W-1] ? '0 : pop_n[SP_W-1:0];
  assign wsp_inc  = wsp_q + 1'b1;
  assign log_rd_cnt = log_cnt_q - 1'b1;

  // status
  assign stat_o.in_op     = in_data_i.opcode;
  assign stat_o.tok_zero  = (in_data_i.token_code == '0);
  assign stat_o.bits_nz   = ((acc_q & tv) != '0);
  assign stat_o.tv_le0    = (tv <= 16'sd0);
  assign stat_o.tv_gt0    = (tv > 16'sd0);
  assign stat_o.tv_lt0    = (tv < 16'sd0);
  assign stat_o.tv_m1     = (tv == -16'sd1);
  assign stat_o.push_ovf  = (int'(wsp_q) >= STACK_DEPTH - 1);
  assign stat_o.pop_ovf   = !pop_n[IDX_W-1] && (pop_n >= IDX_W'(STACK_DEPTH));
  assign stat_o.log_full  = (int'(log_cnt_q) >= STACK_DEPTH);
  assign stat_o.log_empty = (log_cnt_q == '0);
  assign stat_o.nred_max  = (int'(nred_q) >= MAX_REDUCTIONS);
  assign stat_o.x_is_acc  = (x_q == accept_q);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // table read address selection
  always_comb begin
    tbl_re = 1'b1;
    rd_tab = TBL_BM;
    rd_idx = '0;
    unique case (cmd_i.op)
      OP_RD_BR:     begin rd_tab = TBL_BR; rd_idx = $signed(IDX_W'(x_q)); end
      OP_RD_BC:     begin rd_tab = TBL_BC; rd_idx = $signed(IDX_W'(t_q)); end
      OP_RD_BM:     begin rd_tab = TBL_BM; rd_idx = sum_idx; end
      OP_RD_BF:     begin rd_tab = TBL_BF; rd_idx = $signed(IDX_W'(t_q)); end
      OP_PUSH_X:    begin rd_tab = TBL_TR; rd_idx = $signed(IDX_W'(x_q)); end
      OP_RD_TC:     begin rd_tab = TBL_TC; rd_idx = $signed(IDX_W'(t_q)); end
      OP_RD_TM:     begin rd_tab = TBL_TM; rd_idx = sum_idx; end
      OP_RD_PL:     begin rd_tab = TBL_PL; rd_idx = IDX_W'(p_q); end
      OP_EMIT_RED:  begin rd_tab = TBL_NR; rd_idx = $signed(IDX_W'(stk_q)); end
      OP_RD_NC:     begin rd_tab = TBL_NC; rd_idx = IDX_W'(p_q); end
      OP_RD_NM:     begin rd_tab = TBL_NM; rd_idx = sum_idx; end
      OP_RD_RR:     begin rd_tab = TBL_RR; rd_idx = $signed(IDX_W'(x_q)); end
      OP_RD_RC:     begin rd_tab = TBL_RC; rd_idx = $signed(IDX_W'(t_q)); end
      OP_RD_RM:     begin rd_tab = TBL_RM; rd_idx = diff_idx; end
      OP_EMIT_NULL: begin rd_tab = TBL_NR; rd_idx = $signed(IDX_W'(x_q)); end
      OP_RD_PL0:    begin rd_tab = TBL_PL; rd_idx = '0; end
      default:      tbl_re = 1'b0;
    endcase
  end

  assign rd_inrange = !rd_idx[IDX_W-1] && (rd_idx < IDX_W'(TABLE_DEPTH));
  assign tbl_raddr  = {rd_tab, rd_idx[TABLE_AW-1:0]};
  assign tbl_waddr  = {in_data_i.table_id, TABLE_AW'(in_data_i.table_index)};
  assign tbl_we     = (cmd_i.op == OP_LOAD) && (in_data_i.opcode == OPC_WRITE)
                   && (int'(in_data_i.table_id) < NUM_TABLES)
                   && (int'(in_data_i.table_index) < TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= in_data_i.table_value;
    if (tbl_re) begin
      tbl_q <= tbl_mem[tbl_raddr];
      oob_q <= !rd_inrange;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (log_we) log_mem[log_cnt_q[SP_W-1:0]] <= log_wdata;
    if (log_re) log_q <= log_mem[log_rd_cnt[SP_W-1:0]];
  end

  // register updates
  always_comb begin
    cs_d       = cs_q;
    st_d       = st_q;
    sv_state_d = sv_state_q;
    sv_top_d   = sv_top_q;
    log_cnt_d  = log_cnt_q;
    x_d        = x_q;
    t_d        = t_q;
    wsp_d      = wsp_q;
    acc_d      = acc_q;
    p_d        = p_q;
    nred_d     = nred_q;
    kind_d     = kind_q;
    stk_we     = 1'b0;
    stk_waddr  = wsp_q;
    stk_wdata  = x_q;
    stk_re     = 1'b0;
    stk_raddr  = wsp_inc;
    log_we     = 1'b0;
    log_re     = 1'b0;
    log_wdata  = '{sp: wsp_q, st: stk_q};
    emit       = 1'b0;
    emit_item  = '{kind: KIND_DONE, production: '0, parser_state: cs_q,
                   stack_depth: 10'(st_q), last: 1'b1};
    unique case (cmd_i.op)
      OP_LOAD: begin
        t_d        = in_data_i.token_code;
        x_d        = cs_q;
        wsp_d      = st_q;
        sv_state_d = cs_q;
        sv_top_d   = st_q;
        log_cnt_d  = '0;
        nred_d     = '0;
        kind_d     = KIND_ERROR;
        if (in_data_i.opcode == OPC_START) begin
          cs_d       = '0;
          st_d       = '0;
          sv_state_d = '0;
          sv_top_d   = '0;
        end
      end
      OP_RD_BC, OP_RD_BF, OP_RD_TC, OP_RD_NC, OP_RD_RC: acc_d = tv;
      OP_PUSH_X: begin
        wsp_d     = wsp_inc;
        stk_we    = 1'b1;
        stk_waddr = wsp_inc;
      end
      OP_SET_P:  p_d = -((WORD_W+1)'(tv));
      OP_SET_PR: p_d = (WORD_W+1)'(tv);
      OP_SET_X:  x_d = tv[ST_W-1:0];
      OP_SHIFT_DONE: begin
        cs_d   = tv[ST_W-1:0];
        st_d   = wsp_q;
        kind_d = KIND_SHIFTED;
      end
      OP_POP: begin
        wsp_d     = pop_sat;
        stk_re    = 1'b1;
        stk_raddr = pop_sat;
      end
      OP_EMIT_RED: begin
        nred_d    = nred_q + 1'b1;
        emit      = 1'b1;
        emit_item = '{kind: KIND_REDUCE, production: p_q[ST_W-1:0],
                      parser_state: stk_q, stack_depth: 10'(wsp_q), last: 1'b0};
      end
      OP_NPUSH: begin
        wsp_d  = wsp_inc;
        stk_re = 1'b1;
      end
      OP_EMIT_NULL: begin
        log_we    = 1'b1;
        log_cnt_d = log_cnt_q + 1'b1;
        stk_we    = 1'b1;
        nred_d    = nred_q + 1'b1;
        emit      = 1'b1;
        emit_item = '{kind: KIND_REDUCE, production: p_q[ST_W-1:0],
                      parser_state: x_q, stack_depth: 10'(wsp_q), last: 1'b0};
      end
      OP_SET_FAIL: kind_d = (lex_q && (t_q == eof_q)) ? KIND_SUSPENDED : KIND_ERROR;
      OP_SET_OVF:  kind_d = KIND_OVERFLOW;
      OP_ACCEPT: begin
        wsp_d  = pop_sat;
        cs_d   = x_q;
        st_d   = pop_sat;
        kind_d = KIND_ACCEPTED;
      end
      OP_RESTORE: begin
        st_d = sv_top_q;
        cs_d = sv_state_q;
      end
      OP_RD_LOG: log_re = 1'b1;
      OP_UNDO: begin
        stk_we    = 1'b1;
        stk_waddr = log_q.sp;
        stk_wdata = log_q.st;
        log_cnt_d = log_rd_cnt;
      end
      OP_EMIT_FIN: begin
        emit      = 1'b1;
        emit_item = '{kind: kind_q, production: '0, parser_state: cs_q,
                      stack_depth: 10'(st_q), last: 1'b1};
      end
      OP_EMIT_DONE: emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_q    <= '0;
      eof_q       <= '0;
      lex_q       <= 1'b0;
      cs_q        <= '0;
      st_q        <= '0;
      sv_state_q  <= '0;
      sv_top_q    <= '0;
      log_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ACCEPT_STATE: accept_q <= cfg_data_i[ST_W-1:0];
          CFG_EOF_TOKEN:    eof_q    <= cfg_data_i[TOK_W-1:0];
          CFG_LEX_MODE:     lex_q    <= cfg_data_i[0];
          default:          ;
        endcase
      end
      cs_q       <= cs_d;
      st_q       <= st_d;
      sv_state_q <= sv_state_d;
      sv_top_q   <= sv_top_d;
      log_cnt_q  <= log_cnt_d;
      if (emit)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    t_q    <= t_d;
    wsp_q  <= wsp_d;
    acc_q  <= acc_d;
    p_q    <= p_d;
    nred_q <= nred_d;
    kind_q <= kind_d;
    if (emit) out_q <= emit_item;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/lr_table_parse_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_table_parse_engine
// table-driven lr parse engine: loads compressed tables and runs tokens
// ----------------------------------------------------------------------------
// start and table write: the done result is registered once the result register is free
// token: a plain shift walks the tables and shifts; reductions and lookahead reduce
//   rounds (with null reductions) come before the final result; a bad token, an error
//   or an overflow undoes the null reductions; accept pops the stack to the final state
// one item in flight, one table read per cycle unless a result stall holds the sequencer
// reset: async active low, clears control and parse state; tables, stack, undo log kept
module lr_table_parse_engine import lrpe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input item channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // controller to datapath command and status back
  cmd_t  cmd;
  stat_t stat;

  // sequencer: walks the tables one dependent read per cycle, runs the
  // reduction chain and the undo pass over the null reduction log
  lrpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // datapath: table memory, state stack, undo log and the result register
  // that lets a finished result wait while the next transfer is taken
  lrpe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hw/rtl/lrpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpe_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "lr_table_parse_engine_assert.svh"

module lrpe_checker import lrpe_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_item_t             out_data_o
);

  `LRPE_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `LRPE_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_data_o), "result changed")
  `LRPE_ASSERT(a_mid_reduce, out_valid_o && !out_data_o.last |-> out_data_o.kind == KIND_REDUCE, "mid")
  `LRPE_ASSERT(a_last_kind, out_valid_o && out_data_o.last |-> out_data_o.kind != KIND_REDUCE, "fin")
  `LRPE_ASSERT_RST(a_rst_idle, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

bind lr_table_parse_engine lrpe_checker u_lrpe_checker (.*);
